>>> src/edl_pkg.sv
// Package for the endstop edge debounce/lockout block: widths, register
// indexes, reset values and the result struct. No dependencies.
package edl_pkg;

    localparam int AGE_W      = 10;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_NORMALLY_CLOSED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_MS      = 2'd2;

    localparam logic             RST_NORMALLY_CLOSED = 1'b0;
    localparam logic [AGE_W-1:0] RST_DEBOUNCE_MS     = 10'd10;
    localparam logic [AGE_W-1:0] RST_LOCKOUT_MS      = 10'd50;

    typedef struct packed {
        logic             fire;
        logic             triggered;
        logic [CNT_W-1:0] edges_seen;
    } result_t;

    function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
        return (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
    endfunction

endpackage

>>> src/endstop_edge_debounce_lockout.sv
// Top level of the endstop edge debounce/lockout block.
// Uses edl_pkg, edl_core and edl_out.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_pin_level, s_ms_tick
//   m_       out  m_valid/m_ready    m_fire, m_triggered, m_edges_seen
//   cfg_     in   cfg_we             cfg_index, cfg_data
//
// One item per clock unless stalled; a result shows the cycle after its item.
// The result register holds one result; an item is taken whenever it is empty
// or being read in the same cycle, so a stalled m_ready stalls s_ready.
// Synchronous active-low reset: mode normally open, debounce 10, lockout 50.
// The single result register loads the result alongside the state update.
module endstop_edge_debounce_lockout (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [edl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [edl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_pin_level,
    input  logic                              s_ms_tick,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_fire,
    output logic                              m_triggered,
    output logic [edl_pkg::CNT_W-1:0]         m_edges_seen
);

    logic             step_en;
    logic             can_load;
    edl_pkg::result_t res_core;
    edl_pkg::result_t res_q;

    assign s_ready = can_load;
    assign step_en = s_valid && can_load;

    edl_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (step_en),
        .pin_level (s_pin_level),
        .ms_tick   (s_ms_tick),
        .res       (res_core)
    );

    edl_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_en),
        .res_in   (res_core),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .can_load (can_load),
        .res_out  (res_q)
    );

    assign m_fire       = res_q.fire;
    assign m_triggered  = res_q.triggered;
    assign m_edges_seen = res_q.edges_seen;

endmodule

>>> src/edl_core.sv
// Debounce/lockout state and config registers, with the single-pass next-state
// and result logic for one item. Depends on edl_pkg.
module edl_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [edl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [edl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                step_en,
    input  logic                                pin_level,
    input  logic                                ms_tick,
    output edl_pkg::result_t                    res
);

    logic                          nc_reg;
    logic [edl_pkg::AGE_W-1:0]     debounce_reg;
    logic [edl_pkg::AGE_W-1:0]     lockout_reg;

    logic                          last_level_reg, last_level_next;
    logic                          pending_reg, pending_next;
    logic [edl_pkg::AGE_W-1:0]     pending_age_reg, pending_age_next;
    logic                          locked_reg, locked_next;
    logic [edl_pkg::AGE_W-1:0]     lock_age_reg, lock_age_next;
    logic [edl_pkg::CNT_W-1:0]     cnt_reg, cnt_next;

    logic [edl_pkg::AGE_W-1:0]     pa_tick, la_tick;
    logic                          locked_rel;
    logic                          active_lvl;
    logic                          edge_acc;
    logic                          pend_mid;
    logic                          fire;
    logic                          pending_upd;

    assign active_lvl = nc_reg;

    always_comb begin
        pa_tick = (ms_tick && pending_reg) ? edl_pkg::age_inc(pending_age_reg)
                                           : pending_age_reg;
        la_tick = (ms_tick && locked_reg) ? edl_pkg::age_inc(lock_age_reg)
                                          : lock_age_reg;
        locked_rel = locked_reg && (la_tick < lockout_reg);
        edge_acc = (last_level_reg != pin_level) && (pin_level == active_lvl)
                   && !locked_rel && !pending_reg;
        pend_mid = pending_reg || edge_acc;
        pending_age_next = edge_acc ? '0 : pa_tick;
        cnt_next = edge_acc ? cnt_reg + 1'b1 : cnt_reg;
        fire = pend_mid && (pending_age_next >= debounce_reg);
        pending_next  = pend_mid && !fire;
        locked_next   = locked_rel || fire;
        lock_age_next = fire ? '0 : la_tick;
        last_level_next = pin_level;
        // mode write drops pending
        pending_upd = (step_en ? pending_next : pending_reg)
                      && !(cfg_we && cfg_index == edl_pkg::REG_NORMALLY_CLOSED);
    end

    assign res.fire       = fire;
    assign res.triggered  = (pin_level == active_lvl);
    assign res.edges_seen = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nc_reg          <= edl_pkg::RST_NORMALLY_CLOSED;
            debounce_reg    <= edl_pkg::RST_DEBOUNCE_MS;
            lockout_reg     <= edl_pkg::RST_LOCKOUT_MS;
            last_level_reg  <= 1'b1;
            pending_reg     <= 1'b0;
            pending_age_reg <= '0;
            locked_reg      <= 1'b0;
            lock_age_reg    <= '0;
            cnt_reg         <= '0;
        end else begin
            pending_reg <= pending_upd;
            if (step_en) begin
                last_level_reg  <= last_level_next;
                pending_age_reg <= pending_age_next;
                locked_reg      <= locked_next;
                lock_age_reg    <= lock_age_next;
                cnt_reg         <= cnt_next;
            end
            // user must write config only while idle; block does not enforce
            if (cfg_we) begin
                unique case (cfg_index)
                    edl_pkg::REG_NORMALLY_CLOSED: begin
                        nc_reg <= cfg_data[0];
                    end
                    edl_pkg::REG_DEBOUNCE_MS: begin
                        debounce_reg <= cfg_data;
                    end
                    edl_pkg::REG_LOCKOUT_MS: begin
                        lockout_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_fire_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && fire |=> !pending_reg && locked_reg && lock_age_reg == '0)
        else $error("fire did not start lockout");

    a_edge_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && edge_acc |=> cnt_reg == $past(cnt_reg) + 1'b1 && pending_age_reg == '0)
        else $error("accepted edge not counted");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(cnt_reg) && $stable(pending_age_reg) && $stable(lock_age_reg))
        else $error("state moved without an item");

endmodule

>>> src/edl_out.sv
// Result register for the endstop block: holds one result until taken and
// parts the two channels. Depends on edl_pkg.
module edl_out (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  edl_pkg::result_t   res_in,
    input  logic               m_ready,
    output logic               m_valid,
    output logic               can_load,
    output edl_pkg::result_t   res_out
);

    logic             valid_reg, valid_next;
    edl_pkg::result_t data_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = data_reg;

endmodule

>>> dv/tb_endstop_edge_debounce_lockout.sv
// Testbench for endstop_edge_debounce_lockout: directed table plus random phases,
// every result checked against an in-bench debounce/lockout predictor or a typed-in result.
// Depends on edl_pkg and the endstop_edge_debounce_lockout RTL.
`timescale 1ns / 100ps

module tb_endstop_edge_debounce_lockout;

    localparam int CYCLE_LIMIT = 500000;
    localparam logic ROW_ITEM  = 1'b0;
    localparam logic ROW_WRITE = 1'b1;
    localparam logic [edl_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [edl_pkg::CFG_IDX_W-1:0] NO_IDX = '0;
    localparam edl_pkg::result_t NO_RES = '0;

    typedef struct packed {
        logic                           wr;
        logic [edl_pkg::CFG_IDX_W-1:0]  idx;
        logic [edl_pkg::CFG_DATA_W-1:0] data;
        logic                           pin;
        logic                           tick;
        logic                           chk;
        edl_pkg::result_t               res;
    } dir_row_t;

    typedef struct packed {
        logic [edl_pkg::CFG_DATA_W-1:0] nc_data;
        logic [edl_pkg::AGE_W-1:0]      deb;
        logic [edl_pkg::AGE_W-1:0]      lock;
        logic [11:0]                    n_items;
        logic [6:0]                     tick_pct;
    } phase_t;

    localparam int N_DIR = 28;
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0}},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b1, 32'd1}},
        // rewrite mode with same value: pending edge is dropped
        '{ROW_WRITE, edl_pkg::REG_NORMALLY_CLOSED, 10'd0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, edl_pkg::REG_DEBOUNCE_MS,     10'd1, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, 32'd1}},
        // zero debounce and zero lockout
        '{ROW_WRITE, edl_pkg::REG_DEBOUNCE_MS,     10'd0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, edl_pkg::REG_LOCKOUT_MS,      10'd0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd1}},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd2}},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd2}},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b0, 1'b1, '{1'b1, 1'b1, 32'd3}},
        // normally closed, upper data bits set
        '{ROW_WRITE, edl_pkg::REG_NORMALLY_CLOSED, 10'h3FF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, edl_pkg::REG_DEBOUNCE_MS,     10'd2, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, edl_pkg::REG_LOCKOUT_MS,      10'd3, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        // unknown index must be ignored
        '{ROW_WRITE, REG_UNUSED,                   10'h3FF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_ITEM,  NO_IDX, 10'd0, 1'b1, 1'b1, 1'b0, NO_RES}
    };

    localparam int N_PHASES = 6;
    localparam phase_t PHASES [N_PHASES] = '{
        '{10'h000, 10'd10,   10'd50,   12'd80,  7'd70},
        '{10'h001, 10'd0,    10'd0,    12'd70,  7'd30},
        '{10'h2AA, 10'd3,    10'd5,    12'd70,  7'd50},
        // longest times: accepted edges never fire within the phase
        '{10'h3FF, 10'd1023, 10'd1023, 12'd70,  7'd100},
        '{10'h155, 10'd1,    10'd2,    12'd80,  7'd50},
        '{10'h000, 10'd0,    10'd7,    12'd70,  7'd60}
    };

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [edl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [edl_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_pin_level;
    logic                           s_ms_tick;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_fire;
    logic                           m_triggered;
    logic [edl_pkg::CNT_W-1:0]      m_edges_seen;

    // typed-in result travels with the item it belongs to
    logic             typed_chk;
    edl_pkg::result_t typed_res;
    logic             calm;

    // predictor copy of registers and state
    logic                      mode_nc;
    logic [edl_pkg::AGE_W-1:0] debounce_lim;
    logic [edl_pkg::AGE_W-1:0] lockout_lim;
    logic                      prev_level;
    logic                      edge_pending;
    logic [edl_pkg::AGE_W-1:0] pending_age;
    logic                      locked_out;
    logic [edl_pkg::AGE_W-1:0] lock_age;
    logic [edl_pkg::CNT_W-1:0] edge_count;

    edl_pkg::result_t outcome_q [$];
    int               fail_count = 0;
    int               stall_left = 0;
    int unsigned      cycle_count = 0;

    endstop_edge_debounce_lockout DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pin_level  (s_pin_level),
        .s_ms_tick    (s_ms_tick),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fire       (m_fire),
        .m_triggered  (m_triggered),
        .m_edges_seen (m_edges_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // one pin sample: tick ages, release, edge accept, fire
    function automatic edl_pkg::result_t endstop_step(input logic pin, input logic tick);
        edl_pkg::result_t r;
        logic             act_edge;
        r = '0;
        if (tick) begin
            if (edge_pending && pending_age != edl_pkg::AGE_MAX)
                pending_age = pending_age + 1'b1;
            if (locked_out && lock_age != edl_pkg::AGE_MAX)
                lock_age = lock_age + 1'b1;
        end
        if (locked_out && lock_age >= lockout_lim)
            locked_out = 1'b0;
        act_edge = (prev_level != pin) && (pin == mode_nc);
        if (act_edge && !locked_out && !edge_pending) begin
            edge_count   = edge_count + 1'b1;
            edge_pending = 1'b1;
            pending_age  = '0;
        end
        if (edge_pending && pending_age >= debounce_lim) begin
            edge_pending = 1'b0;
            locked_out   = 1'b1;
            lock_age     = '0;
            r.fire       = 1'b1;
        end
        prev_level  = pin;
        r.triggered  = (pin == mode_nc);
        r.edges_seen = edge_count;
        return r;
    endfunction

    // monitor, predictor and result-side stalls
    always @(posedge aclk) begin
        edl_pkg::result_t want;
        if (!aresetn) begin
            mode_nc      = edl_pkg::RST_NORMALLY_CLOSED;
            debounce_lim = edl_pkg::RST_DEBOUNCE_MS;
            lockout_lim  = edl_pkg::RST_LOCKOUT_MS;
            prev_level   = 1'b1;
            edge_pending = 1'b0;
            pending_age  = '0;
            locked_out   = 1'b0;
            lock_age     = '0;
            edge_count   = '0;
            stall_left   = 0;
            m_ready     <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result fire=%0b triggered=%0b edges_seen=%0d",
                             $time, m_fire, m_triggered, m_edges_seen);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (want.fire !== m_fire) begin
                        $display("%0t: fire expected %0b actual %0b",
                                 $time, want.fire, m_fire);
                        fail_count++;
                    end
                    if (want.triggered !== m_triggered) begin
                        $display("%0t: triggered expected %0b actual %0b",
                                 $time, want.triggered, m_triggered);
                        fail_count++;
                    end
                    if (want.edges_seen !== m_edges_seen) begin
                        $display("%0t: edges_seen expected %0d actual %0d",
                                 $time, want.edges_seen, m_edges_seen);
                        fail_count++;
                    end
                end
                stall_left = draw_gap();
            end
            if (cfg_we) begin
                case (cfg_index)
                    edl_pkg::REG_NORMALLY_CLOSED: begin
                        mode_nc      = cfg_data[0];
                        edge_pending = 1'b0;
                    end
                    edl_pkg::REG_DEBOUNCE_MS: debounce_lim = cfg_data;
                    edl_pkg::REG_LOCKOUT_MS:  lockout_lim  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = endstop_step(s_pin_level, s_ms_tick);
                if (typed_chk)
                    want = typed_res;
                outcome_q.push_back(want);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ends at the edge where the item is taken, valid still high
    task automatic send_item(input logic pin, input logic tick, input logic chk,
                             input edl_pkg::result_t res);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pin_level <= pin;
        s_ms_tick   <= tick;
        typed_chk   <= chk;
        typed_res   <= res;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [edl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [edl_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic        pin_now;
        logic        tick_now;
        logic [31:0] rnd;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_pin_level = 1'b1;
        s_ms_tick   = 1'b0;
        typed_chk   = 1'b0;
        typed_res   = '0;
        calm        = 1'b0;
        pin_now     = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_TAB[i].wr == ROW_WRITE) begin
                wait_idle();
                cfg_write(DIR_TAB[i].idx, DIR_TAB[i].data);
            end else begin
                send_item(DIR_TAB[i].pin, DIR_TAB[i].tick, DIR_TAB[i].chk, DIR_TAB[i].res);
                pin_now = DIR_TAB[i].pin;
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            calm <= ($urandom_range(0, 3) == 0);
            cfg_write(edl_pkg::REG_NORMALLY_CLOSED, PHASES[p].nc_data);
            cfg_write(edl_pkg::REG_DEBOUNCE_MS, PHASES[p].deb);
            cfg_write(edl_pkg::REG_LOCKOUT_MS, PHASES[p].lock);
            if ($urandom_range(0, 1)) begin
                rnd = $urandom_range(0, 1023);
                cfg_write(REG_UNUSED, rnd[edl_pkg::CFG_DATA_W-1:0]);
            end
            for (int k = 0; k < PHASES[p].n_items; k++) begin
                if ($urandom_range(0, 59) == 0) begin
                    // mode rewrite mid-phase may land on a pending edge
                    wait_idle();
                    cfg_write(edl_pkg::REG_NORMALLY_CLOSED, PHASES[p].nc_data);
                end else if ($urandom_range(0, 49) == 0) begin
                    wait_idle();
                    calm <= ~calm;
                end
                if ($urandom_range(0, 99) < 40)
                    pin_now = ~pin_now;
                tick_now = ($urandom_range(0, 99) < PHASES[p].tick_pct);
                send_item(pin_now, tick_now, 1'b0, NO_RES);
            end
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && outcome_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> endstop_edge_debounce_lockout.f
src/edl_pkg.sv
src/edl_core.sv
src/edl_out.sv
src/endstop_edge_debounce_lockout.sv
dv/tb_endstop_edge_debounce_lockout.sv
